// ===== sv/op_token_stream_with_repeat_count_defines.svh =====
// assertion helpers shared by the rtl files
`ifndef OP_TOKEN_STREAM_WITH_REPEAT_COUNT_DEFINES_SVH
`define OP_TOKEN_STREAM_WITH_REPEAT_COUNT_DEFINES_SVH

// same-cycle implication, off while reset is held
`define OTSRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define OTSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/otsrc_pkg.sv =====
package otsrc_pkg;

    localparam int KIND_W  = 4;
    localparam int COUNT_W = 17;

    // op codes
    localparam logic [KIND_W-1:0] KIND_INC   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_DEC   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LEFT  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_RIGHT = 4'd3;
    localparam logic [KIND_W-1:0] KIND_WAIT  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_LOOP  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_LEND  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_RPT   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 4'd8;
    localparam logic [KIND_W-1:0] KIND_BOPEN = 4'd9;
    localparam logic [KIND_W-1:0] KIND_BEND  = 4'd10;
    localparam logic [KIND_W-1:0] KIND_DONE  = 4'd11;

    // character codes
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_LBRC   = 8'h7B;
    localparam logic [7:0] CH_RBRC   = 8'h7D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_result;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
    } t_cmd;

    // scanner to queue: 0..2 results of one request
    typedef struct packed {
        logic [1:0] n;
        t_result    res0;
        t_result    res1;
    } t_scan_out;

    function automatic logic f_is_digit(input logic [7:0] b);
        return b inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic f_is_stopper(input logic [7:0] b);
        return (b inside {CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_DOT, CH_COMMA,
                          CH_LBRK, CH_RBRK, CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC,
                          CH_STAR, CH_PCT}) || f_is_digit(b);
    endfunction

    // commands that map straight to a token (close paren is not one)
    function automatic t_cmd f_cmd(input logic [7:0] b);
        t_cmd c;
        c.hit  = 1'b1;
        c.kind = KIND_INC;
        case (b)
            CH_PLUS:  c.kind = KIND_INC;
            CH_MINUS: c.kind = KIND_DEC;
            CH_LT:    c.kind = KIND_LEFT;
            CH_GT:    c.kind = KIND_RIGHT;
            CH_DOT:   c.kind = KIND_WAIT;
            CH_LBRK:  c.kind = KIND_LOOP;
            CH_RBRK:  c.kind = KIND_LEND;
            CH_LPAR:  c.kind = KIND_RPT;
            CH_LBRC:  c.kind = KIND_BOPEN;
            CH_RBRC:  c.kind = KIND_BEND;
            default:  c.hit  = 1'b0;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/otsrc_scan.sv =====
`include "op_token_stream_with_repeat_count_defines.svh"

module otsrc_scan #(
    parameter int MAX_COUNT = 100000
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_text_byte,
    input  logic                i_end_of_text,
    output otsrc_pkg::t_scan_out o_scan
);
    import otsrc_pkg::*;

    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam int VW = CW + 4;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_COUNT);
    localparam logic [VW-1:0] MAX_V = VW'(MAX_COUNT);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_CLOSE  = 2'd1;
    localparam logic [1:0] MODE_STAR   = 2'd2;
    localparam logic [1:0] MODE_DIGITS = 2'd3;

    logic [1:0]    r_mode, n_mode;
    logic [CW-1:0] r_acc, n_acc;
    logic          r_neg, n_neg;

    t_cmd          cmd;
    logic          is_dig, is_stop;
    logic [VW-1:0] v_next;
    logic          over;
    logic [CW-1:0] fin_cnt;
    logic          pre_v, run_idle, post_v, post_done;
    logic [CW-1:0] pre_cnt;
    logic [KIND_W-1:0] post_kind;
    t_result       pre_res, post_res;

    always_comb begin
        cmd     = f_cmd(i_text_byte);
        is_dig  = f_is_digit(i_text_byte);
        is_stop = f_is_stopper(i_text_byte);
        // acc * 10 + digit while in digits, just the digit right after the star
        if (r_mode == MODE_DIGITS) begin
            v_next = (VW'(r_acc) << 3) + (VW'(r_acc) << 1) + VW'(i_text_byte[3:0]);
        end else begin
            v_next = VW'(i_text_byte[3:0]);
        end
        over    = v_next > MAX_V;
        fin_cnt = (r_neg && (r_acc != '0)) ? MAX_C : r_acc;

        n_mode    = r_mode;
        n_acc     = r_acc;
        n_neg     = r_neg;
        pre_v     = 1'b0;
        pre_cnt   = '0;
        run_idle  = 1'b0;
        post_done = 1'b0;

        if (i_end_of_text) begin
            pre_v     = r_mode != MODE_IDLE;
            pre_cnt   = (r_mode == MODE_DIGITS) ? fin_cnt : '0;
            post_done = 1'b1;
            n_mode    = MODE_IDLE;
            n_acc     = '0;
            n_neg     = 1'b0;
        end else begin
            case (r_mode)
                MODE_CLOSE: begin
                    if (i_text_byte == CH_STAR || i_text_byte == CH_PCT) begin
                        n_mode = MODE_STAR;
                    end else if (is_stop) begin
                        pre_v    = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                MODE_STAR: begin
                    if (i_text_byte == CH_MINUS) begin
                        n_mode = MODE_DIGITS;
                        n_neg  = 1'b1;
                        n_acc  = '0;
                    end else if (is_dig) begin
                        if (over) begin
                            pre_v   = 1'b1;
                            pre_cnt = MAX_C;
                            n_mode  = MODE_IDLE;
                            n_acc   = '0;
                            n_neg   = 1'b0;
                        end else begin
                            n_mode = MODE_DIGITS;
                            n_neg  = 1'b0;
                            n_acc  = v_next[CW-1:0];
                        end
                    end else if (is_stop) begin
                        pre_v    = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                MODE_DIGITS: begin
                    if (is_dig) begin
                        if (over) begin
                            pre_v   = 1'b1;
                            pre_cnt = MAX_C;
                            n_mode  = MODE_IDLE;
                            n_acc   = '0;
                            n_neg   = 1'b0;
                        end else begin
                            n_acc = v_next[CW-1:0];
                        end
                    end else begin
                        pre_v    = 1'b1;
                        pre_cnt  = fin_cnt;
                        run_idle = 1'b1;
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase
        end

        // byte handled as in idle after any flushed close
        post_kind = post_done ? KIND_DONE : cmd.kind;
        post_v    = post_done || (run_idle && cmd.hit);
        if (run_idle) begin
            n_mode = MODE_IDLE;
            n_acc  = '0;
            n_neg  = 1'b0;
            if (i_text_byte == CH_RPAR) begin
                n_mode = MODE_CLOSE;
            end
        end

        pre_res.kind   = KIND_CLOSE;
        pre_res.count  = COUNT_W'(pre_cnt);
        pre_res.last   = !post_v;
        post_res.kind  = post_kind;
        post_res.count = '0;
        post_res.last  = 1'b1;

        o_scan.n    = 2'(pre_v) + 2'(post_v);
        o_scan.res0 = pre_v ? pre_res : post_res;
        o_scan.res1 = post_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_neg  <= 1'b0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_neg  <= n_neg;
        end
    end

    `OTSRC_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_fire && i_end_of_text, r_mode == MODE_IDLE && r_acc == '0 && !r_neg, "end of text did not clear scan state")
    `OTSRC_ASSERT_NOW(a_pair_is_close, i_clk, i_rst_n, i_fire && o_scan.n == 2'd2, o_scan.res0.kind == KIND_CLOSE && !o_scan.res0.last, "two results without leading close")
    `OTSRC_ASSERT_NOW(a_acc_bound, i_clk, i_rst_n, 1'b1, r_acc <= MAX_C, "count accumulator above limit")

endmodule

// ===== sv/otsrc_outq.sv =====
`include "op_token_stream_with_repeat_count_defines.svh"

module otsrc_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  otsrc_pkg::t_scan_out i_scan,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_stall,
    output otsrc_pkg::t_result   o_res
);
    import otsrc_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = PW + 1;

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_head, r_tail;
    logic [CNTW-1:0] r_count;
    logic [1:0]      push_n;
    logic            pop;

    assign push_n  = i_push ? i_scan.n : 2'd0;
    assign pop     = o_valid && !i_stall;
    assign o_valid = r_count != '0;
    // room only while two free slots are left for the worst request
    assign o_room  = r_count <= CNTW'(DEPTH - 2);
    assign o_res   = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_tail] <= i_scan.res0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_tail + PW'(1)] <= i_scan.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + PW'(push_n);
            r_head  <= r_head + PW'(pop);
            r_count <= r_count + CNTW'(push_n) - CNTW'(pop);
        end
    end

    `OTSRC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNTW'(DEPTH), "queue count above depth")
    `OTSRC_ASSERT_NOW(a_push_room, i_clk, i_rst_n, push_n != 2'd0, r_count <= CNTW'(DEPTH - 2), "push without room")
    `OTSRC_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, i_rst_n, r_count == CNTW'($past(r_count) + CNTW'($past(push_n)) - CNTW'($past(pop))), "queue count lost track")

endmodule

// ===== sv/op_token_stream_with_repeat_count.sv =====
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+----------------------------------------------
// text     | in  | i_valid / o_stall  | i_text_byte, i_end_of_text
// token    | out | o_valid / i_stall  | o_op_kind, o_repeat_count, o_last_of_run
//
// one request per cycle while o_stall is low; each is held in the input register,
// then goes to the queue, and its tokens reach the port from the queue
// a request makes zero, one or two tokens; the port drains one per cycle unless i_stall,
// so the single read port of the result queue sets the sustained rate
// synchronous active-low reset returns the scanner to idle and empties the queue
// o_stall rises only while the held request waits for two free queue slots

module op_token_stream_with_repeat_count #(
    parameter int MAX_COUNT = 100000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // text requests
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    // tokens
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_op_kind,
    output logic [16:0] o_repeat_count,
    output logic        o_last_of_run
);
    import otsrc_pkg::*;

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    logic       accept;
    logic       fire;
    logic       room;
    t_scan_out  scan;
    t_result    head_res;

    // held request moves into the queue once two slots are free
    assign fire    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_text_byte;
            r_in_end  <= i_end_of_text;
        end
    end

    // close-scan state machine and token forming
    otsrc_scan #(
        .MAX_COUNT (MAX_COUNT)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_text_byte   (r_in_byte),
        .i_end_of_text (r_in_end),
        .o_scan        (scan)
    );

    // result queue, also the output register
    otsrc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_scan  (scan),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (head_res)
    );

    assign o_op_kind      = head_res.kind;
    assign o_repeat_count = head_res.count;
    assign o_last_of_run  = head_res.last;

endmodule
